FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the descriptor slot allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed");

// An antecedent that implies a consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/dsa_pkg.sv
// ----------------------------------------------------------------------------
// dsa_pkg
// Types, sizes and codes for the descriptor slot allocator.
// ----------------------------------------------------------------------------
package dsa_pkg;

	// Table geometry.
	localparam int DEPTH    = 4096;
	localparam int RSV      = 3;
	localparam int SLOT_W   = $clog2(DEPTH);
	localparam int CNT_W    = SLOT_W + 1;
	localparam int WORD_W   = 64;
	localparam int BIT_W    = $clog2(WORD_W);
	localparam int NWORDS   = DEPTH / WORD_W;
	localparam int WADDR_W  = $clog2(NWORDS);
	localparam int RSV_IW   = (RSV > 1) ? $clog2(RSV) : 1;

	// Object type codes.
	localparam logic [3:0] TYPE_FILE = 4'd1;
	localparam logic [3:0] TYPE_PIPE = 4'd3;

	// Request kinds.
	typedef enum logic [2:0] {
		K_ALLOC   = 3'd0,
		K_RELEASE = 3'd1,
		K_DUP     = 3'd2,
		K_DUP_TGT = 3'd3,
		K_LOOKUP  = 3'd4,
		K_SET_OFF = 3'd5,
		K_SET_FLG = 3'd6,
		K_COUNT   = 3'd7
	} kind_t;

	// Request transaction.
	typedef struct packed {
		kind_t              kind;
		logic [SLOT_W-1:0]  slot;
		logic [SLOT_W-1:0]  target_slot;
		logic [3:0]         entry_type;
		logic [31:0]        host_handle;
		logic [31:0]        open_flags;
		logic [31:0]        access_mode;
		logic [63:0]        file_offset;
	} req_t;

	// Response transaction.
	typedef struct packed {
		logic               ok;
		logic [SLOT_W-1:0]  result_slot;
		logic [3:0]         read_type;
		logic [31:0]        read_handle;
		logic [31:0]        read_flags;
		logic [31:0]        read_mode;
		logic [63:0]        read_offset;
		logic [CNT_W-1:0]   open_count;
		logic               host_close;
		logic [31:0]        close_handle;
	} rsp_t;

	// One descriptor record as held in the table.
	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] handle;
		logic [31:0] flags;
		logic [31:0] mode;
		logic [63:0] offset;
	} rec_t;

	// Contents of a reserved slot before it is first written.
	function automatic rec_t reset_rec(input logic [SLOT_W-1:0] s);
		rec_t r;
		r.kind   = TYPE_FILE;
		r.handle = '0;
		r.flags  = (s == '0) ? 32'd0 : 32'd1;
		r.mode   = '0;
		r.offset = '0;
		return r;
	endfunction

	// True when a released record asks the host to close its handle.
	function automatic logic needs_close(input rec_t r);
		return ((r.kind == TYPE_FILE) || (r.kind == TYPE_PIPE)) && (r.handle != '0);
	endfunction

endpackage

FILE: rtl/descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// descriptor_slot_allocator
// Descriptor table with a next-fit allocator over a word-wide busy bitmap.
// ----------------------------------------------------------------------------
//  channel | signals                     | payload
//  request | req_valid, req_stall, req   | req_t
//  response| rsp_valid, rsp_stall, rsp   | rsp_t
//
// A request is taken only in the idle state and passes through read and check
// states; an allocation also scans the bitmap, one 64-bit word per read/check pair.
// After reset a clearing pass writes the 64 bitmap words, and no request is
// taken until it ends. A finished response waits in the output register while the
// next request is taken; processing holds only if that register is still full.
`include "assert_macros.svh"

module descriptor_slot_allocator import dsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [7:0] {
		ST_CLEAR   = 8'b0000_0001,
		ST_IDLE    = 8'b0000_0010,
		ST_RD_SRC  = 8'b0000_0100,
		ST_CHK_SRC = 8'b0000_1000,
		ST_CHK_DST = 8'b0001_0000,
		ST_SRCH_RD = 8'b0010_0000,
		ST_SRCH_CK = 8'b0100_0000,
		ST_RESP    = 8'b1000_0000
	} state_t;

	state_t               state_q;
	req_t                 req_q;
	rsp_t                 pend_q;
	rsp_t                 rsp_q;
	rsp_t                 rsp_next;
	logic                 rsp_valid_q;
	rec_t                 cpy_rec_q;
	logic [CNT_W-1:0]     busy_count_q;
	logic [CNT_W-1:0]     search_q;
	logic [WADDR_W-1:0]   clr_idx_q;
	logic [WADDR_W-1:0]   srch_w_q;
	logic                 srch_ph2_q;
	logic [RSV-1:0]       rsv_wr_q;

	// Busy bitmap and record table.
	logic [WORD_W-1:0]    bm_mem [NWORDS];
	rec_t                 rec_mem [DEPTH];
	logic [WORD_W-1:0]    bm_rdata_q;
	rec_t                 rec_rdata_q;
	logic [SLOT_W-1:0]    rec_rsel_q;

	logic [WADDR_W-1:0]   bm_raddr;
	logic [SLOT_W-1:0]    rec_raddr;
	logic                 bm_we;
	logic [WADDR_W-1:0]   bm_waddr;
	logic [WORD_W-1:0]    bm_wdata;
	logic                 rec_we;
	logic [SLOT_W-1:0]    rec_waddr;
	rec_t                 rec_wdata;

	rec_t                 rec_view;
	logic                 src_live;
	logic                 dst_busy;
	logic [WORD_W-1:0]    scan_word;
	logic                 scan_hit;
	logic [BIT_W-1:0]     scan_idx;
	logic [SLOT_W-1:0]    found_slot;
	logic [WADDR_W:0]     start_w;
	logic                 srch_last;

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Record as read, with reserved slots showing reset contents until written.
	always_comb begin
		rec_view = rec_rdata_q;
		if ((rec_rsel_q < SLOT_W'(RSV)) && !rsv_wr_q[rec_rsel_q[RSV_IW-1:0]]) begin
			rec_view = reset_rec(rec_rsel_q);
		end
	end

	assign src_live = bm_rdata_q[req_q.slot[BIT_W-1:0]];
	assign dst_busy = bm_rdata_q[req_q.target_slot[BIT_W-1:0]];

	// Search window: the first word of the upper pass hides slots below the pointer.
	assign start_w = search_q[CNT_W-1:BIT_W];
	always_comb begin
		scan_word = bm_rdata_q;
		if (!srch_ph2_q && ({1'b0, srch_w_q} == start_w)) begin
			scan_word = bm_rdata_q | ((WORD_W'(1) << search_q[BIT_W-1:0]) - WORD_W'(1));
		end
	end

	// First free bit in the scanned word.
	always_comb begin
		scan_hit = 1'b0;
		scan_idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!scan_word[i]) begin
				scan_hit = 1'b1;
				scan_idx = BIT_W'(i);
			end
		end
	end

	assign found_slot = {srch_w_q, scan_idx};
	assign srch_last  = (srch_w_q == WADDR_W'(NWORDS - 1)) || ({1'b0, srch_w_q} == start_w);

	// Response as loaded, with the busy count after the request.
	always_comb begin
		rsp_next            = pend_q;
		rsp_next.open_count = busy_count_q;
	end

	// Read addresses are set for the state that consumes the registered data in the next cycle.
	always_comb begin
		bm_raddr  = req_q.slot[SLOT_W-1:BIT_W];
		rec_raddr = req_q.slot;
		if (state_q == ST_CHK_SRC) begin
			bm_raddr  = req_q.target_slot[SLOT_W-1:BIT_W];
			rec_raddr = req_q.target_slot;
		end else if (state_q == ST_SRCH_RD) begin
			bm_raddr = srch_w_q;
		end
	end

	// Table writes.
	always_comb begin
		bm_we     = 1'b0;
		bm_waddr  = req_q.slot[SLOT_W-1:BIT_W];
		bm_wdata  = bm_rdata_q;
		rec_we    = 1'b0;
		rec_waddr = req_q.slot;
		rec_wdata = rec_view;
		case (state_q)
			ST_CLEAR: begin
				bm_we    = 1'b1;
				bm_waddr = clr_idx_q;
				bm_wdata = (clr_idx_q == '0) ? WORD_W'((1 << RSV) - 1) : '0;
			end
			ST_CHK_SRC: begin
				case (req_q.kind)
					K_RELEASE: begin
						bm_we    = src_live && (req_q.slot >= SLOT_W'(RSV));
						bm_wdata = bm_rdata_q & ~(WORD_W'(1) << req_q.slot[BIT_W-1:0]);
					end
					K_SET_OFF: begin
						rec_we           = src_live;
						rec_wdata.offset = req_q.file_offset;
					end
					K_SET_FLG: begin
						rec_we          = src_live;
						rec_wdata.flags = req_q.open_flags;
					end
					default: begin
					end
				endcase
			end
			ST_CHK_DST: begin
				bm_we     = 1'b1;
				bm_waddr  = req_q.target_slot[SLOT_W-1:BIT_W];
				bm_wdata  = bm_rdata_q | (WORD_W'(1) << req_q.target_slot[BIT_W-1:0]);
				rec_we    = 1'b1;
				rec_waddr = req_q.target_slot;
				rec_wdata = cpy_rec_q;
			end
			ST_SRCH_CK: begin
				bm_we     = scan_hit;
				bm_waddr  = srch_w_q;
				bm_wdata  = bm_rdata_q | (WORD_W'(1) << scan_idx);
				rec_we    = scan_hit;
				rec_waddr = found_slot;
				rec_wdata = cpy_rec_q;
			end
			default: begin
			end
		endcase
	end

	// Memories: one write and one registered read each.
	always_ff @(posedge clk) begin
		if (bm_we) begin
			bm_mem[bm_waddr] <= bm_wdata;
		end
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		bm_rdata_q  <= bm_mem[bm_raddr];
		rec_rdata_q <= rec_mem[rec_raddr];
		rec_rsel_q  <= rec_raddr;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			req_q        <= '0;
			pend_q       <= '0;
			rsp_q        <= '0;
			cpy_rec_q    <= '0;
			rsp_valid_q  <= 1'b0;
			busy_count_q <= CNT_W'(RSV);
			search_q     <= CNT_W'(RSV);
			clr_idx_q    <= '0;
			srch_w_q     <= '0;
			srch_ph2_q   <= 1'b0;
			rsv_wr_q     <= '0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != ST_RESP)) begin
				rsp_valid_q <= 1'b0;
			end
			if (rec_we && (rec_waddr < SLOT_W'(RSV))) begin
				rsv_wr_q[rec_waddr[RSV_IW-1:0]] <= 1'b1;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == WADDR_W'(NWORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req;
						pend_q  <= '0;
						state_q <= ST_RD_SRC;
					end
				end
				ST_RD_SRC: begin
					state_q <= ST_CHK_SRC;
				end
				ST_CHK_SRC: begin
					state_q <= ST_RESP;
					case (req_q.kind)
						K_ALLOC: begin
							cpy_rec_q <= '{kind: req_q.entry_type, handle: req_q.host_handle,
								flags: req_q.open_flags, mode: req_q.access_mode, offset: '0};
							srch_ph2_q <= (search_q >= CNT_W'(DEPTH));
							srch_w_q   <= (search_q >= CNT_W'(DEPTH)) ? '0
								: search_q[SLOT_W-1:BIT_W];
							state_q    <= ST_SRCH_RD;
						end
						K_RELEASE: begin
							if (src_live && (req_q.slot >= SLOT_W'(RSV))) begin
								pend_q.ok <= 1'b1;
								busy_count_q <= busy_count_q - 1'b1;
								if (needs_close(rec_view)) begin
									pend_q.host_close   <= 1'b1;
									pend_q.close_handle <= rec_view.handle;
								end
							end
						end
						K_DUP: begin
							if (src_live) begin
								cpy_rec_q  <= '{kind: rec_view.kind, handle: rec_view.handle,
									flags: rec_view.flags, mode: rec_view.mode, offset: '0};
								srch_ph2_q <= (search_q >= CNT_W'(DEPTH));
								srch_w_q   <= (search_q >= CNT_W'(DEPTH)) ? '0
									: search_q[SLOT_W-1:BIT_W];
								state_q    <= ST_SRCH_RD;
							end
						end
						K_DUP_TGT: begin
							if (src_live) begin
								pend_q.ok          <= 1'b1;
								pend_q.result_slot <= req_q.target_slot;
								cpy_rec_q          <= rec_view;
								if (req_q.target_slot != req_q.slot) begin
									state_q <= ST_CHK_DST;
								end
							end
						end
						K_LOOKUP: begin
							if (src_live) begin
								pend_q.ok          <= 1'b1;
								pend_q.read_type   <= rec_view.kind;
								pend_q.read_handle <= rec_view.handle;
								pend_q.read_flags  <= rec_view.flags;
								pend_q.read_mode   <= rec_view.mode;
								pend_q.read_offset <= rec_view.offset;
							end
						end
						K_SET_OFF, K_SET_FLG: begin
							pend_q.ok <= src_live;
						end
						default: begin
							pend_q.ok <= 1'b1;
						end
					endcase
				end
				ST_CHK_DST: begin
					// A freed target is taken again at once, so the count holds.
					if (!dst_busy) begin
						busy_count_q <= busy_count_q + 1'b1;
					end else if ((req_q.target_slot >= SLOT_W'(RSV)) && needs_close(rec_view)) begin
						pend_q.host_close   <= 1'b1;
						pend_q.close_handle <= rec_view.handle;
					end
					state_q <= ST_RESP;
				end
				ST_SRCH_RD: begin
					state_q <= ST_SRCH_CK;
				end
				ST_SRCH_CK: begin
					if (scan_hit) begin
						pend_q.ok          <= 1'b1;
						pend_q.result_slot <= found_slot;
						busy_count_q       <= busy_count_q + 1'b1;
						search_q           <= {1'b0, found_slot} + 1'b1;
						state_q            <= ST_RESP;
					end else if (srch_ph2_q && srch_last) begin
						state_q <= ST_RESP;
					end else if (!srch_ph2_q && (srch_w_q == WADDR_W'(NWORDS - 1))) begin
						srch_ph2_q <= 1'b1;
						srch_w_q   <= '0;
						state_q    <= ST_SRCH_RD;
					end else begin
						srch_w_q <= srch_w_q + 1'b1;
						state_q  <= ST_SRCH_RD;
					end
				end
				ST_RESP: begin
					if (!rsp_valid_q || !rsp_stall) begin
						rsp_q       <= rsp_next;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks.
	`ASSERT_ALWAYS(a_count_range, clk, arst_n, busy_count_q <= CNT_W'(DEPTH))
	`ASSERT_ALWAYS(a_search_range, clk, arst_n, (search_q >= CNT_W'(RSV)) && (search_q <= CNT_W'(DEPTH)))
	`ASSERT_IMPLIES(a_rsp_from_seq, clk, arst_n, $rose(rsp_valid_q), $past(state_q) == ST_RESP)

endmodule

FILE: tb/dsa_checker.sv
// ----------------------------------------------------------------------------
// dsa_checker
// Watches the request and response channels of the descriptor slot
// allocator, keeps its own copy of the descriptor table and compares every
// response transaction with the one predicted for the oldest open request.
// ----------------------------------------------------------------------------
module dsa_checker import dsa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_stall,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_stall,
	input  rsp_t rsp,
	output int   fails,
	output int   pending
);

	// Shadow descriptor table.
	logic        tbl_busy   [DEPTH];
	logic [3:0]  tbl_kind   [DEPTH];
	logic [31:0] tbl_handle [DEPTH];
	logic [31:0] tbl_flags  [DEPTH];
	logic [31:0] tbl_mode   [DEPTH];
	logic [63:0] tbl_offset [DEPTH];
	int          next_fit_ptr;
	int          open_slots;

	// Responses predicted for requests that were taken but not yet answered.
	rsp_t        rsp_expected_q[$];

	assign pending = rsp_expected_q.size();

	// Frees a busy non-reserved slot and reports a host close if one is owed.
	function automatic bit release_entry(input int s, inout logic cl, inout logic [31:0] ch);
		if (s < RSV || s >= DEPTH || !tbl_busy[s])
			return 0;
		if ((tbl_kind[s] == TYPE_FILE || tbl_kind[s] == TYPE_PIPE) && tbl_handle[s] != 0) begin
			cl = 1'b1;
			ch = tbl_handle[s];
		end
		tbl_busy[s]   = 1'b0;
		tbl_handle[s] = '0;
		if (open_slots > 0)
			open_slots--;
		return 1;
	endfunction

	// Next-fit allocation; returns DEPTH when the table is full.
	function automatic int claim_entry(input logic [3:0] k, input logic [31:0] h,
			input logic [31:0] f, input logic [31:0] m);
		int s;
		s = DEPTH;
		for (int i = next_fit_ptr; i < DEPTH && s == DEPTH; i++)
			if (!tbl_busy[i])
				s = i;
		for (int i = RSV; i < next_fit_ptr && s == DEPTH; i++)
			if (!tbl_busy[i])
				s = i;
		if (s < DEPTH) begin
			tbl_kind[s]   = k;
			tbl_handle[s] = h;
			tbl_flags[s]  = f;
			tbl_mode[s]   = m;
			tbl_offset[s] = '0;
			tbl_busy[s]   = 1'b1;
			open_slots++;
			next_fit_ptr  = s + 1;
		end
		return s;
	endfunction

	// Applies one request to the shadow table and returns its response.
	function automatic rsp_t apply_request(input req_t r);
		rsp_t e;
		int   s, d, w;
		bit   live;
		e = '0;
		s = r.slot;
		d = r.target_slot;
		live = tbl_busy[s];
		case (r.kind)
			K_ALLOC: begin
				w = claim_entry(r.entry_type, r.host_handle, r.open_flags, r.access_mode);
				if (w < DEPTH) begin
					e.ok = 1'b1;
					e.result_slot = SLOT_W'(w);
				end
			end
			K_RELEASE: e.ok = release_entry(s, e.host_close, e.close_handle);
			K_DUP: begin
				if (live) begin
					w = claim_entry(tbl_kind[s], tbl_handle[s], tbl_flags[s], tbl_mode[s]);
					if (w < DEPTH) begin
						e.ok = 1'b1;
						e.result_slot = SLOT_W'(w);
					end
				end
			end
			K_DUP_TGT: begin
				if (live) begin
					e.ok = 1'b1;
					e.result_slot = SLOT_W'(d);
					// Copying a slot onto itself leaves everything alone.
					if (d != s) begin
						if (tbl_busy[d])
							void'(release_entry(d, e.host_close, e.close_handle));
						if (!tbl_busy[d])
							open_slots++;
						tbl_kind[d]   = tbl_kind[s];
						tbl_handle[d] = tbl_handle[s];
						tbl_flags[d]  = tbl_flags[s];
						tbl_mode[d]   = tbl_mode[s];
						tbl_offset[d] = tbl_offset[s];
						tbl_busy[d]   = 1'b1;
					end
				end
			end
			K_LOOKUP: begin
				if (live) begin
					e.ok          = 1'b1;
					e.read_type   = tbl_kind[s];
					e.read_handle = tbl_handle[s];
					e.read_flags  = tbl_flags[s];
					e.read_mode   = tbl_mode[s];
					e.read_offset = tbl_offset[s];
				end
			end
			K_SET_OFF: begin
				if (live) begin
					e.ok = 1'b1;
					tbl_offset[s] = r.file_offset;
				end
			end
			K_SET_FLG: begin
				if (live) begin
					e.ok = 1'b1;
					tbl_flags[s] = r.open_flags;
				end
			end
			default: e.ok = 1'b1;
		endcase
		e.open_count = CNT_W'(open_slots);
		return e;
	endfunction

	// Reports one field that differs from its prediction.
	function automatic void field_check(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			fails++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endfunction

	// Prediction on each accepted request, comparison on each accepted response.
	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				tbl_busy[i]   = (i < RSV);
				tbl_kind[i]   = (i < RSV) ? TYPE_FILE : 4'd0;
				tbl_handle[i] = '0;
				tbl_flags[i]  = (i > 0 && i < RSV) ? 32'd1 : 32'd0;
				tbl_mode[i]   = '0;
				tbl_offset[i] = '0;
			end
			next_fit_ptr = RSV;
			open_slots   = RSV;
			rsp_expected_q.delete();
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (rsp_expected_q.size() == 0) begin
					fails++;
					$display("%0t: response with nothing expected, actual %h", $time, rsp);
				end else begin
					e = rsp_expected_q.pop_front();
					field_check("ok",           e.ok,           rsp.ok);
					field_check("result_slot",  e.result_slot,  rsp.result_slot);
					field_check("read_type",    e.read_type,    rsp.read_type);
					field_check("read_handle",  e.read_handle,  rsp.read_handle);
					field_check("read_flags",   e.read_flags,   rsp.read_flags);
					field_check("read_mode",    e.read_mode,    rsp.read_mode);
					field_check("read_offset",  e.read_offset,  rsp.read_offset);
					field_check("open_count",   e.open_count,   rsp.open_count);
					field_check("host_close",   e.host_close,   rsp.host_close);
					field_check("close_handle", e.close_handle, rsp.close_handle);
				end
			end
			if (req_valid && !req_stall)
				rsp_expected_q.push_back(apply_request(req));
		end
	end

endmodule

FILE: tb/tb_descriptor_slot_allocator.sv
// ----------------------------------------------------------------------------
// tb_descriptor_slot_allocator
// Drives directed and random descriptor requests into the allocator, with
// bursty requests and a patterned response stall, and reports the verdict
// from the checker's failure count and pending responses.
// ----------------------------------------------------------------------------
module tb_descriptor_slot_allocator;
	import dsa_pkg::*;

	localparam int CYCLE_LIMIT = 6000000;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic req_valid = 1'b0;
	logic rsp_stall = 1'b0;
	req_t req       = '0;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;
	int   fails;
	int   pending;

	int   burst_left = 0;
	bit   no_gaps    = 0;
	bit   hold_go    = 0;
	int   hold_left  = 0;
	int   cycles     = 0;

	descriptor_slot_allocator uut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	dsa_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.fails(fails), .pending(pending)
	);

	// Clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Response stall: a pattern that steps through four phases, plus a
	// long hold-off on request.
	always @(posedge clk) begin
		int phase;
		phase = (cycles / 300) % 4;
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left--;
		end else if (hold_go) begin
			hold_go   = 0;
			hold_left = 600;
			rsp_stall <= 1'b1;
		end else begin
			case (phase)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 7) == 0);
				2: rsp_stall <= ($urandom_range(0, 1) == 0);
				default: rsp_stall <= ((cycles % 5) < 2);
			endcase
		end
	end

	// Offers one request transaction, with random gaps between bursts.
	task automatic send(input req_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (!no_gaps) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		req       <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		burst_left--;
	endtask

	function automatic req_t make_req(input kind_t k, input int s, input int d);
		req_t r;
		r.kind        = k;
		r.slot        = SLOT_W'(s);
		r.target_slot = SLOT_W'(d);
		r.entry_type  = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(1, 3));
		r.host_handle = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
		r.open_flags  = $urandom;
		r.access_mode = $urandom;
		r.file_offset = {$urandom, $urandom};
		return r;
	endfunction

	// Slots are drawn mostly from the low end, where allocations land, unless wide.
	function automatic int pick_slot(input bit wide);
		int c;
		c = $urandom_range(0, 9);
		if (wide || c == 6 || c == 7)
			return $urandom_range(0, DEPTH - 1);
		if (c == 8)
			return DEPTH - 1 - $urandom_range(0, 3);
		if (c == 9)
			return $urandom_range(0, RSV);
		return $urandom_range(0, 48);
	endfunction

	function automatic req_t random_req(input bit wide);
		kind_t k;
		case ($urandom_range(0, 15))
			0, 1, 2, 3, 4: k = K_ALLOC;
			5, 6, 14, 15:  k = K_RELEASE;
			7:             k = K_DUP;
			8:             k = K_DUP_TGT;
			9, 10:         k = K_LOOKUP;
			11:            k = K_SET_OFF;
			12:            k = K_SET_FLG;
			default:       k = K_COUNT;
		endcase
		return make_req(k, pick_slot(wide), pick_slot(wide));
	endfunction

	task automatic drain();
		while (pending != 0) @(posedge clk);
	endtask

	// Stimulus and verdict.
	initial begin
		req_t r;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests.
		r = make_req(K_ALLOC, 0, 0);
		r.entry_type = TYPE_FILE; r.host_handle = 32'hFFFF_FFFF;
		send(r);                                            // slot 3, file with handle
		r = make_req(K_ALLOC, 0, 0);
		r.entry_type = TYPE_PIPE; r.host_handle = 32'h1234_5678;
		send(r);                                            // slot 4, pipe
		r = make_req(K_ALLOC, 0, 0);
		r.entry_type = 4'd2; r.host_handle = 32'h5555_AAAA;
		send(r);                                            // slot 5, socket
		r = make_req(K_ALLOC, 0, 0);
		r.entry_type = 4'd15; r.open_flags = '1; r.access_mode = '1;
		send(r);                                            // slot 6
		r = make_req(K_ALLOC, 0, 0);
		r.entry_type = 4'd0; r.host_handle = '0; r.open_flags = '0; r.access_mode = '0;
		send(r);                                            // slot 7
		send(make_req(K_LOOKUP, 0, 0));
		send(make_req(K_LOOKUP, 2, 0));
		send(make_req(K_RELEASE, 0, 0));                    // reserved slot stays
		send(make_req(K_RELEASE, DEPTH - 1, 0));            // not busy
		r = make_req(K_SET_OFF, 3, 0); r.file_offset = '1;
		send(r);
		r = make_req(K_SET_FLG, 3, 0); r.open_flags = '0;
		send(r);
		send(make_req(K_LOOKUP, 3, 0));
		send(make_req(K_DUP, 3, 0));                        // dup to free slot
		send(make_req(K_DUP_TGT, 4, 4));                    // onto itself
		send(make_req(K_DUP_TGT, 3, 4));                    // onto busy pipe target
		send(make_req(K_DUP_TGT, 5, 2));                    // onto reserved target
		send(make_req(K_DUP_TGT, 5, DEPTH - 1));            // onto a free target
		send(make_req(K_LOOKUP, DEPTH - 1, 0));
		send(make_req(K_RELEASE, 4, 0));                    // file copy with handle
		send(make_req(K_RELEASE, 5, 0));                    // socket, no close
		send(make_req(K_DUP, 40, 0));                       // source not busy
		send(make_req(K_SET_OFF, 40, 0));
		send(make_req(K_SET_FLG, 40, 0));
		send(make_req(K_COUNT, 0, 0));
		send(make_req(K_LOOKUP, 2, 0));

		// Random traffic with a long response hold-off part way through.
		for (int i = 0; i < 1000; i++) begin
			if (i == 400) begin
				no_gaps = 1;
				hold_go = 1;
			end
			if (i == 700)
				no_gaps = 0;
			send(random_req(0));
		end
		req_valid <= 1'b0;
		drain();

		// More random traffic, the last part spread over the whole table.
		for (int i = 0; i < 1000; i++)
			send(random_req(i >= 700));

		// Finish: wait out every response and the tail latency.
		req_valid <= 1'b0;
		drain();
		repeat (300) @(posedge clk);
		if (fails == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
